>>> sv/bom_detect_line_start_indexer_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte-order-mark detector and row indexer
// Each macro checks one implication on the rising clock edge outside reset.
// ----------------------------------------------------------------------------
`ifndef BOM_DETECT_LINE_START_INDEXER_TOP_ASSERT_SVH
`define BOM_DETECT_LINE_START_INDEXER_TOP_ASSERT_SVH

// same-cycle implication
`define BDLI_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BDLI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bdli_pkg.sv
// ----------------------------------------------------------------------------
// bdli_pkg
// Types, codes and helper functions shared by the indexer modules.
// ----------------------------------------------------------------------------
package bdli_pkg;

   localparam int HEAD_DEPTH  = 4;
   localparam int MAX_RESULTS = 5;

   localparam logic [1:0] KIND_REPORT = 2'd0;
   localparam logic [1:0] KIND_ROW    = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   localparam logic [2:0] ENC_ANSI  = 3'd0;
   localparam logic [2:0] ENC_UTF8  = 3'd1;
   localparam logic [2:0] ENC_U16LE = 3'd2;
   localparam logic [2:0] ENC_U16BE = 3'd3;
   localparam logic [2:0] ENC_U32LE = 3'd4;
   localparam logic [2:0] ENC_U32BE = 3'd5;

   localparam logic [7:0] BYTE_ZERO   = 8'h00;
   localparam logic [7:0] BYTE_FE     = 8'hfe;
   localparam logic [7:0] BYTE_FF     = 8'hff;
   localparam logic [7:0] BYTE_EF     = 8'hef;
   localparam logic [7:0] BYTE_BB     = 8'hbb;
   localparam logic [7:0] BYTE_BF     = 8'hbf;
   localparam logic [7:0] BYTE_CR     = 8'h0d;
   localparam logic [7:0] BYTE_LF     = 8'h0a;
   localparam logic [7:0] BYTE_FILLER = 8'h61;

   typedef enum logic [1:0] {
      PH_DETECT,
      PH_SCAN,
      PH_REJECT
   } bdli_phase_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_file;
   } bdli_item_type;

   typedef struct packed {
      logic [1:0]  record_kind;
      logic [31:0] byte_offset;
   } bdli_entry_type;

   typedef struct packed {
      bdli_entry_type [MAX_RESULTS-1:0] entries;
      logic [2:0]                       count;
      logic [2:0]                       encoding;
   } bdli_batch_type;

   typedef struct packed {
      logic           load;
      bdli_batch_type batch;
   } bdli_load_type;

   typedef struct packed {
      logic can_load;
   } bdli_status_type;

   typedef struct packed {
      logic       nl_run;
      logic       half;
      logic [7:0] hold;
      logic       emit;
   } bdli_scan_type;

   function automatic logic [2:0] decide_encoding(logic [7:0] h0, logic [7:0] h1,
                                                  logic [7:0] h2, logic [7:0] h3);
      logic [2:0] enc;
      priority if (h0 == BYTE_ZERO && h1 == BYTE_ZERO && h2 == BYTE_FE && h3 == BYTE_FF)
         enc = ENC_U32BE;
      else if (h0 == BYTE_FF && h1 == BYTE_FE && h2 == BYTE_ZERO && h3 == BYTE_ZERO)
         enc = ENC_U32LE;
      else if (h0 == BYTE_EF && h1 == BYTE_BB && h2 == BYTE_BF)
         enc = ENC_UTF8;
      else if (h0 == BYTE_FE && h1 == BYTE_FF)
         enc = ENC_U16BE;
      else if (h0 == BYTE_FF && h1 == BYTE_FE)
         enc = ENC_U16LE;
      else
         enc = ENC_ANSI;
      return enc;
   endfunction

   function automatic logic is_u16(logic [2:0] enc);
      return (enc == ENC_U16LE) || (enc == ENC_U16BE);
   endfunction

   function automatic logic is_u32(logic [2:0] enc);
      return (enc == ENC_U32LE) || (enc == ENC_U32BE);
   endfunction

   function automatic logic [2:0] bom_size(logic [2:0] enc);
      logic [2:0] size;
      if (enc == ENC_UTF8)
         size = 3'd3;
      else if (is_u16(enc))
         size = 3'd2;
      else
         size = 3'd0;
      return size;
   endfunction

   function automatic bdli_scan_type scan_step(bdli_scan_type s_in, logic [2:0] enc,
                                               logic [7:0] b);
      bdli_scan_type s;
      logic [15:0]   unit;
      logic          check;
      logic          nl;
      s      = s_in;
      s.emit = 1'b0;
      check  = 1'b1;
      unit   = {8'h00, b};
      if (is_u16(enc)) begin
         if (!s.half) begin
            s.hold = b;
            s.half = 1'b1;
            check  = 1'b0;
         end else begin
            s.half = 1'b0;
            unit   = (enc == ENC_U16BE) ? {s.hold, b} : {b, s.hold};
         end
      end
      nl = (unit == {8'h00, BYTE_CR}) || (unit == {8'h00, BYTE_LF});
      if (check) begin
         if (s.nl_run) begin
            if (!nl) begin
               s.emit   = 1'b1;
               s.nl_run = 1'b0;
            end
         end else if (nl) begin
            s.nl_run = 1'b1;
         end
      end
      return s;
   endfunction

   function automatic bdli_batch_type push_entry(bdli_batch_type b_in, logic [1:0] kind,
                                                 logic [31:0] offset);
      bdli_batch_type b;
      b = b_in;
      if (b.count < 3'(MAX_RESULTS)) begin
         b.entries[b.count].record_kind = kind;
         b.entries[b.count].byte_offset = offset;
         b.count = b.count + 3'd1;
      end
      return b;
   endfunction

endpackage

>>> sv/bdli_req_if.sv
// ----------------------------------------------------------------------------
// bdli_req_if
// Input byte channel: valid/ready handshake with byte and end-of-file flag.
// ----------------------------------------------------------------------------
interface bdli_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_file;

   modport source (output valid, output byte_value, output end_of_file, input ready);
   modport sink (input valid, input byte_value, input end_of_file, output ready);
endinterface

>>> sv/bdli_rsp_if.sv
// ----------------------------------------------------------------------------
// bdli_rsp_if
// Result channel: valid/ready handshake with one result record per transfer.
// ----------------------------------------------------------------------------
interface bdli_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  record_kind;
   logic [2:0]  encoding;
   logic [31:0] byte_offset;
   logic        last_in_run;

   modport source (output valid, output record_kind, output encoding,
                   output byte_offset, output last_in_run, input ready);
   modport sink (input valid, input record_kind, input encoding,
                 input byte_offset, input last_in_run, output ready);
endinterface

>>> sv/bdli_in_stage.sv
// ----------------------------------------------------------------------------
// bdli_in_stage
// Input register: captures one byte per transfer and holds it for the engine.
// ----------------------------------------------------------------------------
module bdli_in_stage
   import bdli_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   bdli_req_if.sink      req_chan,
   input  logic          item_take,
   output logic          item_valid,
   output bdli_item_type item
);

   logic          valid_ff;
   logic          valid_in;
   bdli_item_type item_ff;
   logic          accept;

   assign req_chan.ready = !valid_ff || item_take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      if (accept)
         valid_in = 1'b1;
      else if (item_take)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.byte_value  <= req_chan.byte_value;
         item_ff.end_of_file <= req_chan.end_of_file;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> sv/bdli_engine.sv
// ----------------------------------------------------------------------------
// bdli_engine
// Per-file state, encoding decision, head replay and unit scan; builds the
// batch of results that one byte causes.
// ----------------------------------------------------------------------------
module bdli_engine
   import bdli_pkg::*;
#(
   parameter int OFFSET_BITS = 32
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  bdli_item_type   item,
   input  bdli_status_type out_status,
   output logic            item_take,
   output bdli_load_type   load_out
);

   logic [7:0]             head_ff [HEAD_DEPTH];
   logic [7:0]             head_in [HEAD_DEPTH];
   logic [2:0]             head_count_ff, head_count_in;
   bdli_phase_type         phase_ff, phase_in;
   logic [2:0]             kind_ff, kind_in;
   logic                   nl_run_ff, nl_run_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [7:0]             hold_ff, hold_in;
   logic                   half_ff, half_in;

   logic [2:0]             new_count;
   logic                   decide_now;
   logic [7:0]             bytes_now [HEAD_DEPTH];
   logic [7:0]             head_view [HEAD_DEPTH];
   logic [2:0]             dec_kind;
   bdli_batch_type         batch;

   function automatic logic [31:0] to_out(logic [OFFSET_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[31:0];
   endfunction

   // decision inputs
   always_comb begin
      new_count  = head_count_ff + 3'd1;
      decide_now = (new_count == 3'(HEAD_DEPTH)) || item.end_of_file;
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         bytes_now[i] = (head_count_ff == 3'(i)) ? item.byte_value : head_ff[i];
         head_view[i] = (3'(i) < new_count) ? bytes_now[i] : BYTE_FILLER;
      end
      dec_kind = decide_encoding(head_view[0], head_view[1], head_view[2], head_view[3]);
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_DETECT: begin
            if (decide_now)
               phase_in = is_u32(dec_kind) ? PH_REJECT : PH_SCAN;
         end
         PH_SCAN:   phase_in = PH_SCAN;
         PH_REJECT: phase_in = PH_REJECT;
         default:   phase_in = PH_DETECT;
      endcase
      if (item.end_of_file)
         phase_in = PH_DETECT;
   end

   // data path and result batch
   always_comb begin
      bdli_scan_type s;
      logic [2:0]    bom;
      logic [31:0]   row_at;
      head_in       = head_ff;
      head_count_in = head_count_ff;
      kind_in       = kind_ff;
      nl_run_in     = nl_run_ff;
      offset_in     = offset_ff;
      hold_in       = hold_ff;
      half_in       = half_ff;
      batch          = '0;
      batch.encoding = kind_ff;
      s.nl_run = nl_run_ff;
      s.half   = half_ff;
      s.hold   = hold_ff;
      s.emit   = 1'b0;
      bom      = bom_size(dec_kind);
      row_at   = '0;
      unique case (phase_ff)
         PH_DETECT: begin
            head_in[head_count_ff[1:0]] = item.byte_value;
            head_count_in = new_count;
            if (decide_now) begin
               kind_in        = dec_kind;
               batch.encoding = dec_kind;
               batch = push_entry(batch, KIND_REPORT, 32'd0);
               if (!is_u32(dec_kind)) begin
                  batch = push_entry(batch, KIND_ROW, {29'd0, bom});
                  s.nl_run = 1'b0;
                  s.half   = 1'b0;
                  s.hold   = hold_ff;
                  for (int i = 0; i < HEAD_DEPTH; i++) begin
                     if ((3'(i) < new_count) && (3'(i) >= bom)) begin
                        s = scan_step(s, dec_kind, bytes_now[i]);
                        row_at = 32'(i) - (is_u16(dec_kind) ? 32'd1 : 32'd0);
                        if (s.emit)
                           batch = push_entry(batch, KIND_ROW, row_at);
                     end
                  end
                  nl_run_in = s.nl_run;
                  half_in   = s.half;
                  hold_in   = s.hold;
                  offset_in = OFFSET_BITS'(new_count);
                  if (item.end_of_file)
                     batch = push_entry(batch, KIND_END, {29'd0, new_count});
               end
            end
         end
         PH_SCAN: begin
            s = scan_step(s, kind_ff, item.byte_value);
            nl_run_in = s.nl_run;
            half_in   = s.half;
            hold_in   = s.hold;
            if (s.emit)
               batch = push_entry(batch, KIND_ROW,
                                  to_out(is_u16(kind_ff) ? offset_ff - OFFSET_BITS'(1)
                                                         : offset_ff));
            offset_in = offset_ff + OFFSET_BITS'(1);
            if (item.end_of_file)
               batch = push_entry(batch, KIND_END, to_out(offset_in));
         end
         PH_REJECT: begin
            head_count_in = head_count_ff;
         end
         default: begin
            head_count_in = head_count_ff;
         end
      endcase
      if (item.end_of_file) begin
         head_count_in = '0;
         kind_in       = ENC_ANSI;
         nl_run_in     = 1'b0;
         offset_in     = '0;
         hold_in       = '0;
         half_in       = 1'b0;
      end
   end

   assign item_take      = item_valid && ((batch.count == 3'd0) || out_status.can_load);
   assign load_out.load  = item_take && (batch.count != 3'd0);
   assign load_out.batch = batch;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_count_ff <= '0;
         phase_ff      <= PH_DETECT;
         kind_ff       <= ENC_ANSI;
         nl_run_ff     <= 1'b0;
         offset_ff     <= '0;
         hold_ff       <= '0;
         half_ff       <= 1'b0;
      end else if (item_take) begin
         head_count_ff <= head_count_in;
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         nl_run_ff     <= nl_run_in;
         offset_ff     <= offset_in;
         hold_ff       <= hold_in;
         half_ff       <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take)
         head_ff <= head_in;
   end

endmodule

>>> sv/bdli_out_stage.sv
// ----------------------------------------------------------------------------
// bdli_out_stage
// Result register: holds one batch and presents its records one per transfer.
// ----------------------------------------------------------------------------
module bdli_out_stage
   import bdli_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  bdli_load_type   load_in,
   output bdli_status_type out_status,
   bdli_rsp_if.source      rsp_chan
);

   logic           busy_ff, busy_in;
   logic [2:0]     idx_ff, idx_in;
   bdli_batch_type batch_ff;
   logic           last;
   logic           xfer;
   bdli_entry_type entry;

   assign entry = batch_ff.entries[idx_ff];
   assign last  = (idx_ff == (batch_ff.count - 3'd1));
   assign xfer  = busy_ff && rsp_chan.ready;

   assign rsp_chan.valid       = busy_ff;
   assign rsp_chan.record_kind = entry.record_kind;
   assign rsp_chan.encoding    = batch_ff.encoding;
   assign rsp_chan.byte_offset = entry.byte_offset;
   assign rsp_chan.last_in_run = last;

   assign out_status.can_load = !busy_ff || (xfer && last);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load_in.load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (xfer) begin
         if (last)
            busy_in = 1'b0;
         else
            idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in.load)
         batch_ff <= load_in.batch;
   end

endmodule

>>> sv/bom_detect_line_start_indexer_top.sv
// ----------------------------------------------------------------------------
// bom_detect_line_start_indexer_top: byte-order-mark detector and row indexer
// Synchronous reset clears control and per-file state.
// Throughput: one byte per cycle while the result register can take a batch;
// a byte with results holds that register until its last record is taken.
// ----------------------------------------------------------------------------
`include "bom_detect_line_start_indexer_top_assert.svh"

module bom_detect_line_start_indexer_top
   import bdli_pkg::*;
#(
   parameter int OFFSET_BITS = 32
)
(
   input  logic       clock,
   input  logic       reset,
   bdli_req_if.sink   req_chan,
   bdli_rsp_if.source rsp_chan
);

   logic            item_valid;
   logic            item_take;
   bdli_item_type   item;
   bdli_load_type   eng_load;
   bdli_status_type out_status;

   bdli_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item       (item)
   );

   bdli_engine #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_status (out_status),
      .item_take  (item_take),
      .load_out   (eng_load)
   );

   bdli_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load_in    (eng_load),
      .out_status (out_status),
      .rsp_chan   (rsp_chan)
   );

`BDLI_ASSERT_NEXT(a_batch_gapless, rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_in_run, rsp_chan.valid, "batch broken before its last record")
`BDLI_ASSERT_IMPLIES(a_load_when_free, eng_load.load, out_status.can_load, "batch loaded over a pending one")
`BDLI_ASSERT_IMPLIES(a_kind_legal, rsp_chan.valid, rsp_chan.record_kind == KIND_REPORT || rsp_chan.record_kind == KIND_ROW || rsp_chan.record_kind == KIND_END, "illegal record kind")

endmodule
